// ===== design/mpba_pkg.sv =====
// Shared types and constants for the multi-pool bump allocator.
// Holds the beat structs, request and status codes and the
// controller/datapath command and status bundles. No dependencies.
package mpba_pkg;

  // Fixed field widths of the request and result beats
  localparam int POOL_ID_W  = 6;
  localparam int CHUNK_W    = 32;
  localparam int SIZE_W     = 48;
  localparam int IN_ADDR_W  = 48;
  localparam int IN_COUNT_W = 32;
  localparam int OUT_ADDR_W = 48;

  // Divide/multiply loop: one dividend bit per step
  localparam int STEP_W = $clog2(SIZE_W + 1);

  // Request codes
  localparam logic [1:0] REQ_INIT   = 2'd0;
  localparam logic [1:0] REQ_SETCAP = 2'd1;
  localparam logic [1:0] REQ_ALLOC  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_GRANT  = 2'd0;
  localparam logic [1:0] ST_REFUSE = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [POOL_ID_W-1:0]  pool_id;
    logic [IN_ADDR_W-1:0]  base_addr;
    logic [CHUNK_W-1:0]    chunk_bytes;
    logic [IN_COUNT_W-1:0] chunk_count;
    logic [SIZE_W-1:0]     alloc_bytes;
  } mpba_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [OUT_ADDR_W-1:0] grant_addr;
  } mpba_out_t;

  // What the captured request turns out to be
  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_SETCAP,
    KIND_ALLOC,
    KIND_BAD
  } mpba_kind_t;

  // Which result the datapath loads into the output register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_GRANT,
    EMIT_REFUSE,
    EMIT_ACCEPT
  } mpba_emit_t;

  typedef struct packed {
    logic       capture;
    logic       clr_wr;
    logic       ram_rd;
    logic       wr_cfg;
    logic       wr_alloc;
    logic       iter_load;
    logic       iter_step;
    mpba_emit_t emit;
  } mpba_cmd_t;

  typedef struct packed {
    mpba_kind_t kind;
    logic       cs_zero;
    logic       clr_last;
    logic       iter_last;
    logic       fits;
  } mpba_sts_t;

endpackage

// ===== design/mpba_ram.sv =====
// Generic single-port RAM with registered read and read enable.
// Used for the pool table; no package dependency.
module mpba_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mpba_datapath.sv =====
// Datapath of the multi-pool bump allocator: request register, pool table,
// shared restoring divider and shift-add multiplier, result register.
// Depends on mpba_pkg and mpba_ram; driven by mpba_ctrl.
module mpba_datapath #(
  parameter int NUM_POOLS   = 64,
  parameter int ADDR_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mpba_pkg::mpba_in_t in_item,
  input  mpba_pkg::mpba_cmd_t cmd,
  output mpba_pkg::mpba_sts_t sts,
  output logic               out_valid,
  output mpba_pkg::mpba_out_t out_item
);
  import mpba_pkg::*;

  localparam int RAM_AW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int ENT_W  = ADDR_WIDTH + CHUNK_W + 2 * COUNT_WIDTH;
  localparam int SUM_W  = ((COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W) + 1;

  mpba_in_t              req_r;
  logic [RAM_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [POOL_ID_W+RAM_AW-1:0] pid_ext;
  logic [RAM_AW-1:0]     pool_addr, ram_addr;
  logic                  ram_we;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic [ADDR_WIDTH-1:0] rd_base;
  logic [CHUNK_W-1:0]    rd_cs;
  logic [COUNT_WIDTH-1:0] rd_cap, rd_next;
  logic                  pid_bad;
  mpba_kind_t            req_kind;

  // Iteration registers
  logic [SIZE_W-1:0]      dvd_r, dvd_nxt;
  logic [CHUNK_W-1:0]     rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] mq_r, mq_nxt;
  logic [ADDR_WIDTH-1:0]  mc_r, mc_nxt;
  logic [ADDR_WIDTH-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [CHUNK_W:0]       rem_sh, rem_diff;
  logic                   rem_ge;

  logic [SUM_W-1:0]       need, idx_sum;

  logic                   out_valid_r, out_valid_nxt;
  mpba_out_t              out_item_r, out_item_nxt;

  // Hold the accepted request beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item;
    end
  end

  // Clearing pass counter
  assign clr_cnt_nxt = cmd.clr_wr ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Pool address and request classification
  assign pid_ext   = {{RAM_AW{1'b0}}, req_r.pool_id};
  assign pool_addr = pid_ext[RAM_AW-1:0];
  assign pid_bad   = 32'(req_r.pool_id) >= 32'(NUM_POOLS);

  always_comb begin
    if (pid_bad) begin
      req_kind = KIND_BAD;
    end else begin
      case (req_r.req_type)
        REQ_INIT:   req_kind = KIND_INIT;
        REQ_SETCAP: req_kind = KIND_SETCAP;
        REQ_ALLOC:  req_kind = KIND_ALLOC;
        default:    req_kind = KIND_BAD;
      endcase
    end
  end

  assign sts.kind = req_kind;

  // Split the table entry
  assign rd_base = ram_rdata[ENT_W-1 -: ADDR_WIDTH];
  assign rd_cs   = ram_rdata[2*COUNT_WIDTH+CHUNK_W-1 -: CHUNK_W];
  assign rd_cap  = ram_rdata[2*COUNT_WIDTH-1 -: COUNT_WIDTH];
  assign rd_next = ram_rdata[COUNT_WIDTH-1:0];

  // Table write: clear, init, set capacity or index advance
  always_comb begin
    ram_wdata = '0;
    if (cmd.wr_cfg) begin
      if (req_r.req_type == REQ_INIT) begin
        ram_wdata = {ADDR_WIDTH'(req_r.base_addr), req_r.chunk_bytes,
                     COUNT_WIDTH'(req_r.chunk_count), {COUNT_WIDTH{1'b0}}};
      end else begin
        ram_wdata = {rd_base, rd_cs, COUNT_WIDTH'(req_r.chunk_count), rd_next};
      end
    end else if (cmd.wr_alloc) begin
      ram_wdata = {rd_base, rd_cs, rd_cap, COUNT_WIDTH'(idx_sum)};
    end
  end

  assign ram_we   = cmd.clr_wr | cmd.wr_cfg | cmd.wr_alloc;
  assign ram_addr = cmd.clr_wr ? clr_cnt_r : pool_addr;

  mpba_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_POOLS)
  ) u_pool_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (cmd.ram_rd),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // One divider bit and one multiplier bit per step
  assign rem_sh   = {rem_r, dvd_r[SIZE_W-1]};
  assign rem_diff = rem_sh - {1'b0, rd_cs};
  assign rem_ge   = rem_sh >= {1'b0, rd_cs};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    mq_nxt   = mq_r;
    mc_nxt   = mc_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    if (cmd.iter_load) begin
      dvd_nxt  = req_r.alloc_bytes;
      rem_nxt  = '0;
      mq_nxt   = rd_next;
      mc_nxt   = ADDR_WIDTH'(rd_cs);
      acc_nxt  = rd_base;
      step_nxt = '0;
    end else if (cmd.iter_step) begin
      dvd_nxt  = {dvd_r[SIZE_W-2:0], rem_ge};
      rem_nxt  = rem_ge ? rem_diff[CHUNK_W-1:0] : rem_sh[CHUNK_W-1:0];
      mq_nxt   = mq_r >> 1;
      mc_nxt   = mc_r << 1;
      acc_nxt  = mq_r[0] ? acc_r + mc_r : acc_r;
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    mq_r   <= mq_nxt;
    mc_r   <= mc_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
  end

  // Round up to whole chunks and test against capacity
  assign need    = SUM_W'(dvd_r) + SUM_W'(rem_r != '0);
  assign idx_sum = SUM_W'(rd_next) + need;

  assign sts.cs_zero   = (rd_cs == '0);
  assign sts.clr_last  = (clr_cnt_r == RAM_AW'(NUM_POOLS - 1));
  assign sts.iter_last = (step_r == STEP_W'(SIZE_W - 1));
  assign sts.fits      = !(idx_sum > SUM_W'(rd_cap));

  // Result register: one beat per emit
  always_comb begin
    out_valid_nxt = 1'b1;
    out_item_nxt  = '0;
    case (cmd.emit)
      EMIT_GRANT: begin
        out_item_nxt.status     = ST_GRANT;
        out_item_nxt.grant_addr = OUT_ADDR_W'(acc_r);
      end
      EMIT_REFUSE: begin
        out_item_nxt.status = ST_REFUSE;
      end
      EMIT_ACCEPT: begin
        out_item_nxt.status = ST_ACCEPT;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/mpba_ctrl.sv =====
// Controller of the multi-pool bump allocator: sequences the clearing pass,
// table read, decision, divide/multiply loop and table write-back.
// Depends on mpba_pkg; drives mpba_datapath.
module mpba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mpba_pkg::mpba_sts_t sts,
  output mpba_pkg::mpba_cmd_t cmd
);
  import mpba_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_ITER   = 6'b010000,
    S_FINISH = 6'b100000
  } mpba_state_t;

  mpba_state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EMIT_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        case (sts.kind)
          KIND_INIT, KIND_SETCAP: begin
            cmd.wr_cfg = 1'b1;
            cmd.emit   = EMIT_ACCEPT;
          end
          KIND_ALLOC: begin
            if (sts.cs_zero) begin
              cmd.emit = EMIT_REFUSE;
            end else begin
              cmd.iter_load = 1'b1;
              state_nxt     = S_ITER;
            end
          end
          default: begin
            cmd.emit = EMIT_REFUSE;
          end
        endcase
      end
      S_ITER: begin
        cmd.iter_step = 1'b1;
        if (sts.iter_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        state_nxt = S_IDLE;
        if (sts.fits) begin
          cmd.wr_alloc = 1'b1;
          cmd.emit     = EMIT_GRANT;
        end else begin
          cmd.emit = EMIT_REFUSE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/multi_pool_bump_allocator.sv =====
// Top level of the multi-pool bump allocator.
// Joins mpba_ctrl and mpba_datapath; types from mpba_pkg.
//
// After reset the block sweeps its pool table to zero, one pool a cycle, and
// busy stays high until every pool is cleared. A request is taken at a clock
// edge where start is high and busy is low; busy then stays high until the
// result beat appears. Init, set-capacity and refused requests (unknown type
// or pool out of range) give their result beat on out_valid after the read
// and decide states, from the result register. An allocate with a non-zero
// chunk size runs a shared loop that resolves one dividend bit of the chunk
// count and one multiplier bit of the address per cycle, over all 48 dividend
// bits, then the finish state loads the result register; busy falls in the
// same cycle the result is shown, and the next request may be taken at that
// edge. The result beat is shown for one cycle only and must be captured
// then: the receiver cannot hold it off.
module multi_pool_bump_allocator #(
  parameter int NUM_POOLS   = 64,
  parameter int ADDR_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mpba_pkg::mpba_in_t  in_item,
  output logic                out_valid,
  output mpba_pkg::mpba_out_t out_item
);
  import mpba_pkg::*;

  mpba_cmd_t cmd;
  mpba_sts_t sts;

  // Sequencer
  mpba_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  // Table and arithmetic
  mpba_datapath #(
    .NUM_POOLS  (NUM_POOLS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

// ===== design/mpba_checker.sv =====
// Port-level checker for the multi-pool bump allocator, bound to the top.
// Depends on mpba_pkg and multi_pool_bump_allocator.
module mpba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mpba_pkg::mpba_in_t  in_item,
  input logic                out_valid,
  input mpba_pkg::mpba_out_t out_item
);
  import mpba_pkg::*;

  // An accepted beat makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  // No result in the cycle right after an accept
  a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result appeared right after accept");

  // Result beats are single-cycle pulses
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // A result is only shown once the block is ready again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Only grants carry an address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_GRANT |-> out_item.grant_addr == '0)
    else $error("non-grant result with non-zero address");

endmodule

bind multi_pool_bump_allocator mpba_checker u_mpba_checker (.*);
